// ----- design/tgc_pkg.sv -----
// ----------------------------------------------------------------------------
// tgc_pkg: shared types and constants of the tilt gesture counter
// Field widths, beat structs, command and register codes, and the
// intermediate result structs passed between the lanes and merge stages.
// ----------------------------------------------------------------------------
package tgc_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int TIME_BITS     = 48;
  localparam int COUNT_BITS    = 4;
  localparam int THR_BITS      = 16;
  localparam int SPAN_BITS     = 24;
  localparam int NUM_LANES     = 3;
  localparam int PROD_BITS     = 2 * SAMPLE_BITS;
  localparam int SQ_BITS       = PROD_BITS - 1;
  localparam int NORM_BITS     = PROD_BITS;
  localparam int DOT_BITS      = PROD_BITS + 2;
  localparam int NM_BITS       = 2 * NORM_BITS;
  localparam int HALF_BITS     = NM_BITS / 2;
  localparam int PART_BITS     = HALF_BITS + THR_BITS;
  localparam int SCALED_BITS   = NM_BITS + THR_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = SPAN_BITS;
  localparam int CNT_BITS      = 3;

  // |g|^2 * |ref|^2 at or below this floor treats the cosine as exactly one.
  localparam logic [NM_BITS-1:0] NORM_FLOOR = NM_BITS'(64'd28147497671);

  // Step-counter value at which the arithmetic stages are finished.
  localparam logic [CNT_BITS-1:0] CALC_LAST = CNT_BITS'(5);

  localparam logic [COUNT_BITS-1:0] RST_GESTURES = COUNT_BITS'(3);
  localparam logic [THR_BITS-1:0]   RST_DOWN_COS = THR_BITS'(49149);
  localparam logic [THR_BITS-1:0]   RST_UP_COS   = THR_BITS'(62684);
  localparam logic [SPAN_BITS-1:0]  RST_SETTLE   = SPAN_BITS'(400000);
  localparam logic [SPAN_BITS-1:0]  RST_HOLD     = SPAN_BITS'(1200000);

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_SHORT   = 2'd2,
    CMD_LONG    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GESTURES = 3'd0,
    CFG_DOWN_COS = 3'd1,
    CFG_UP_COS   = 3'd2,
    CFG_SETTLE   = 3'd3,
    CFG_HOLD     = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    cmd_t                          command;
    logic [TIME_BITS-1:0]          now_time;
    logic                          sample_valid;
    logic signed [SAMPLE_BITS-1:0] grav_x;
    logic signed [SAMPLE_BITS-1:0] grav_y;
    logic signed [SAMPLE_BITS-1:0] grav_z;
  } in_payload_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] gesture_count;
    logic                  is_tilted;
    logic                  reference_ready;
    logic                  gesture_pulse;
    logic                  complete_pulse;
    logic                  advance_pulse;
    logic                  exit_request;
  } out_payload_t;

  typedef struct packed {
    logic [PROD_BITS-1:0] dot;
    logic [SQ_BITS-1:0]   gsq;
    logic [SQ_BITS-1:0]   rsq;
  } lane_res_t;

  typedef struct packed {
    logic [NORM_BITS-1:0] adot;
    logic                 dot_pos;
    logic [NORM_BITS-1:0] n;
    logic [NORM_BITS-1:0] m;
  } merge_res_t;

  typedef struct packed {
    logic below;
    logic above;
  } cos_res_t;

endpackage

// ----- design/tgc_lane.sv -----
// ----------------------------------------------------------------------------
// tgc_lane: per-axis product lane
// Forms the axis term of the dot product and both squared components
// for one axis of the sample and the reference vector.
// ----------------------------------------------------------------------------
module tgc_lane
  import tgc_pkg::*;
(
  input  logic                          clk,
  input  logic signed [SAMPLE_BITS-1:0] g,
  input  logic signed [SAMPLE_BITS-1:0] r,
  output lane_res_t                     res
);

  logic signed [PROD_BITS-1:0] p_dot;
  logic signed [PROD_BITS-1:0] p_gg;
  logic signed [PROD_BITS-1:0] p_rr;
  lane_res_t                   res_r;

  assign p_dot = g * r;
  assign p_gg  = g * g;
  assign p_rr  = r * r;

  // Squares are never negative, so the top bit carries nothing.
  always_ff @(posedge clk) begin
    res_r.dot <= p_dot;
    res_r.gsq <= p_gg[SQ_BITS-1:0];
    res_r.rsq <= p_rr[SQ_BITS-1:0];
  end

  assign res = res_r;

endmodule

// ----- design/tgc_merge.sv -----
// ----------------------------------------------------------------------------
// tgc_merge: lane merge stage
// Sums the lane terms into the dot product and the two squared norms,
// and splits the dot product into sign and magnitude.
// ----------------------------------------------------------------------------
module tgc_merge
  import tgc_pkg::*;
(
  input  logic       clk,
  input  lane_res_t  lanes [NUM_LANES],
  output merge_res_t res
);

  logic signed [DOT_BITS-1:0] dot_sum;
  logic signed [DOT_BITS-1:0] dot_abs;
  merge_res_t                 res_r;

  assign dot_sum = DOT_BITS'($signed(lanes[0].dot)) + DOT_BITS'($signed(lanes[1].dot))
                 + DOT_BITS'($signed(lanes[2].dot));
  assign dot_abs = dot_sum[DOT_BITS-1] ? -dot_sum : dot_sum;

  // The magnitude is at most three full-scale products and fits the norm width.
  always_ff @(posedge clk) begin
    res_r.adot    <= dot_abs[NORM_BITS-1:0];
    res_r.dot_pos <= (dot_sum > 0);
    res_r.n       <= NORM_BITS'(lanes[0].gsq) + NORM_BITS'(lanes[1].gsq)
                   + NORM_BITS'(lanes[2].gsq);
    res_r.m       <= NORM_BITS'(lanes[0].rsq) + NORM_BITS'(lanes[1].rsq)
                   + NORM_BITS'(lanes[2].rsq);
  end

  assign res = res_r;

endmodule

// ----- design/tgc_cosine.sv -----
// ----------------------------------------------------------------------------
// tgc_cosine: squared-cosine threshold compare
// Compares dot^2 * 2^16 against thr * |g|^2 * |ref|^2 for both thresholds
// over four register stages, with the small-norm case forced upright.
// ----------------------------------------------------------------------------
module tgc_cosine
  import tgc_pkg::*;
(
  input  logic                clk,
  input  merge_res_t          mrg,
  input  logic [THR_BITS-1:0] down_cos,
  input  logic [THR_BITS-1:0] up_cos,
  output cos_res_t            res
);

  logic [NM_BITS-1:0]     nm_r;
  logic [NM_BITS-1:0]     asq_r;
  logic                   pos_s1_r;
  logic [PART_BITS-1:0]   dn_lo_r;
  logic [PART_BITS-1:0]   dn_hi_r;
  logic [PART_BITS-1:0]   up_lo_r;
  logic [PART_BITS-1:0]   up_hi_r;
  logic [NM_BITS-1:0]     asq_s2_r;
  logic                   pos_s2_r;
  logic                   degen_s2_r;
  logic [SCALED_BITS-1:0] dn_prod_r;
  logic [SCALED_BITS-1:0] up_prod_r;
  logic [SCALED_BITS-1:0] asq_sh_r;
  logic                   pos_s3_r;
  logic                   degen_s3_r;
  cos_res_t               res_r;

  always_ff @(posedge clk) begin
    nm_r     <= NM_BITS'(mrg.n) * NM_BITS'(mrg.m);
    asq_r    <= NM_BITS'(mrg.adot) * NM_BITS'(mrg.adot);
    pos_s1_r <= mrg.dot_pos;

    // The 64-bit norm product is scaled in two 32-bit halves.
    dn_lo_r    <= PART_BITS'(down_cos) * PART_BITS'(nm_r[HALF_BITS-1:0]);
    dn_hi_r    <= PART_BITS'(down_cos) * PART_BITS'(nm_r[NM_BITS-1:HALF_BITS]);
    up_lo_r    <= PART_BITS'(up_cos) * PART_BITS'(nm_r[HALF_BITS-1:0]);
    up_hi_r    <= PART_BITS'(up_cos) * PART_BITS'(nm_r[NM_BITS-1:HALF_BITS]);
    asq_s2_r   <= asq_r;
    pos_s2_r   <= pos_s1_r;
    degen_s2_r <= (nm_r <= NORM_FLOOR);

    dn_prod_r  <= {dn_hi_r, HALF_BITS'(0)} + SCALED_BITS'(dn_lo_r);
    up_prod_r  <= {up_hi_r, HALF_BITS'(0)} + SCALED_BITS'(up_lo_r);
    asq_sh_r   <= {asq_s2_r, THR_BITS'(0)};
    pos_s3_r   <= pos_s2_r;
    degen_s3_r <= degen_s2_r;

    if (degen_s3_r) begin
      res_r.below <= 1'b0;
      res_r.above <= 1'b1;
    end else begin
      res_r.below <= !pos_s3_r || (asq_sh_r < dn_prod_r);
      res_r.above <= pos_s3_r && (asq_sh_r > up_prod_r);
    end
  end

  assign res = res_r;

endmodule

// ----- design/tilt_gesture_counter_core.sv -----
// ----------------------------------------------------------------------------
// tilt_gesture_counter_core: tilt-and-return gesture counter
// Each accepted beat walks the lane, merge, two multiply, sum and compare
// stages and then the state update; no new beat is taken until it is
// committed, and an unread result with out_stall high holds the decide step.
// A waiting result does not block the next beat, which is taken meanwhile.
// Reset (rst_n low, synchronous) clears the count and flags and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tilt_gesture_counter_core
  import tgc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_payload_t              in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_payload_t             out_data,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  state_t                        state_r, state_nxt;
  logic [CNT_BITS-1:0]           cnt_r, cnt_nxt;
  in_payload_t                   item_r, item_nxt;
  logic                          out_valid_r, out_valid_nxt;
  out_payload_t                  out_data_r, out_data_nxt;

  logic [COUNT_BITS-1:0]         needed_r, needed_nxt;
  logic [THR_BITS-1:0]           down_r, down_nxt;
  logic [THR_BITS-1:0]           up_r, up_nxt;
  logic [SPAN_BITS-1:0]          settle_r, settle_nxt;
  logic [SPAN_BITS-1:0]          hold_r, hold_nxt;

  logic signed [SAMPLE_BITS-1:0] refv_r [NUM_LANES];
  logic signed [SAMPLE_BITS-1:0] refv_nxt [NUM_LANES];
  logic                          have_r, have_nxt;
  logic                          tilted_r, tilted_nxt;
  logic [COUNT_BITS-1:0]         total_r, total_nxt;
  logic                          done_r, done_nxt;
  logic [TIME_BITS-1:0]          done_ts_r, done_ts_nxt;
  logic [TIME_BITS-1:0]          start_ts_r, start_ts_nxt;

  logic                          settle_ok_r;
  logic                          hold_ok_r;
  logic [TIME_BITS-1:0]          since_start;
  logic [TIME_BITS-1:0]          since_done;

  logic signed [SAMPLE_BITS-1:0] g_vec [NUM_LANES];
  lane_res_t                     lane_res [NUM_LANES];
  merge_res_t                    mrg_res;
  cos_res_t                      cos_res;

  logic                          commit;
  logic                          do_count;
  logic [COUNT_BITS-1:0]         inc_total;
  out_payload_t                  res;

  assign g_vec[0] = item_r.grav_x;
  assign g_vec[1] = item_r.grav_y;
  assign g_vec[2] = item_r.grav_z;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    tgc_lane u_lane (
      .clk (clk),
      .g   (g_vec[i]),
      .r   (refv_r[i]),
      .res (lane_res[i])
    );
  end

  tgc_merge u_merge (
    .clk   (clk),
    .lanes (lane_res),
    .res   (mrg_res)
  );

  tgc_cosine u_cosine (
    .clk      (clk),
    .mrg      (mrg_res),
    .down_cos (down_r),
    .up_cos   (up_r),
    .res      (cos_res)
  );

  // Elapsed times wrap modulo the time width, like the timestamps themselves.
  assign since_start = item_r.now_time - start_ts_r;
  assign since_done  = item_r.now_time - done_ts_r;

  always_ff @(posedge clk) begin
    settle_ok_r <= (since_start >= TIME_BITS'(settle_r));
    hold_ok_r   <= (since_done >= TIME_BITS'(hold_r));
    item_r      <= item_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      needed_r    <= RST_GESTURES;
      down_r      <= RST_DOWN_COS;
      up_r        <= RST_UP_COS;
      settle_r    <= RST_SETTLE;
      hold_r      <= RST_HOLD;
      for (int i = 0; i < NUM_LANES; i++) begin
        refv_r[i] <= '0;
      end
      have_r      <= 1'b0;
      tilted_r    <= 1'b0;
      total_r     <= '0;
      done_r      <= 1'b0;
      done_ts_r   <= '0;
      start_ts_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      needed_r    <= needed_nxt;
      down_r      <= down_nxt;
      up_r        <= up_nxt;
      settle_r    <= settle_nxt;
      hold_r      <= hold_nxt;
      for (int i = 0; i < NUM_LANES; i++) begin
        refv_r[i] <= refv_nxt[i];
      end
      have_r      <= have_nxt;
      tilted_r    <= tilted_nxt;
      total_r     <= total_nxt;
      done_r      <= done_nxt;
      done_ts_r   <= done_ts_nxt;
      start_ts_r  <= start_ts_nxt;
    end
  end

  // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
  always_comb begin
    needed_nxt = needed_r;
    down_nxt   = down_r;
    up_nxt     = up_r;
    settle_nxt = settle_r;
    hold_nxt   = hold_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GESTURES: needed_nxt = cfg_wdata[COUNT_BITS-1:0];
        CFG_DOWN_COS: down_nxt   = cfg_wdata[THR_BITS-1:0];
        CFG_UP_COS:   up_nxt     = cfg_wdata[THR_BITS-1:0];
        CFG_SETTLE:   settle_nxt = cfg_wdata[SPAN_BITS-1:0];
        CFG_HOLD:     hold_nxt   = cfg_wdata[SPAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    item_nxt     = item_r;
    commit       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          cnt_nxt   = '0;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cnt_nxt = cnt_r + CNT_BITS'(1);
        if (cnt_r == CALC_LAST) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!out_valid_r || !out_stall) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State update for the item whose arithmetic has just finished.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      refv_nxt[i] = refv_r[i];
    end
    have_nxt     = have_r;
    tilted_nxt   = tilted_r;
    total_nxt    = total_r;
    done_nxt     = done_r;
    done_ts_nxt  = done_ts_r;
    start_ts_nxt = start_ts_r;
    do_count     = 1'b0;
    inc_total    = total_r + COUNT_BITS'(1);
    res          = '0;
    if (commit) begin
      case (item_r.command)
        CMD_RESTART: begin
          have_nxt     = 1'b0;
          tilted_nxt   = 1'b0;
          done_nxt     = 1'b0;
          total_nxt    = '0;
          done_ts_nxt  = '0;
          start_ts_nxt = item_r.now_time;
        end
        CMD_TICK: begin
          if (total_r >= needed_r) begin
            if (done_r && hold_ok_r) begin
              res.advance_pulse = 1'b1;
              done_nxt          = 1'b0;
            end
          end else if (item_r.sample_valid) begin
            if (!have_r) begin
              if (settle_ok_r) begin
                for (int i = 0; i < NUM_LANES; i++) begin
                  refv_nxt[i] = g_vec[i];
                end
                have_nxt = 1'b1;
              end
            end else if (!tilted_r && cos_res.below) begin
              tilted_nxt = 1'b1;
            end else if (tilted_r && cos_res.above) begin
              tilted_nxt = 1'b0;
              do_count   = 1'b1;
            end
          end
        end
        CMD_SHORT: begin
          if (total_r < needed_r) begin
            do_count = 1'b1;
          end
        end
        CMD_LONG: res.exit_request = 1'b1;
        default: ;
      endcase
      if (do_count) begin
        total_nxt         = inc_total;
        res.gesture_pulse = 1'b1;
        if (inc_total >= needed_r) begin
          done_nxt           = 1'b1;
          done_ts_nxt        = item_r.now_time;
          res.complete_pulse = 1'b1;
        end
      end
    end
    res.gesture_count   = total_nxt;
    res.is_tilted       = tilted_nxt;
    res.reference_ready = have_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new result appears only right after the decide step.
  a_out_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DECIDE)
    else $error("result raised outside the decide step");

  // An accepted beat always starts the arithmetic walk from its first step.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_CALC && cnt_r == '0))
    else $error("accepted beat did not start the stage walk");

  // A counted gesture moves the count up by exactly one.
  a_gesture_step: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && res.gesture_pulse) |=>
      (out_data_r.gesture_count == COUNT_BITS'($past(total_r) + COUNT_BITS'(1))))
    else $error("gesture pulse without a single count step");

  // The advance pulse fires once, so the completion flag must be clear after it.
  a_advance_once: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && res.advance_pulse) |=> !done_r)
    else $error("completion flag still set after advance");

endmodule
